[hw/rtl/dbd_pkg.sv]
// Package for the Gregorian day-difference core: field widths, year bound,
// and the calendar helper functions used by days_between_dates_core.
// No dependencies.
package dbd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DiffW  = 23;

  // Upper bound on an accepted year (inclusive).
  localparam int unsigned MaxYear = 9999;
  localparam int unsigned YearCmpW = 17;

  // Reciprocal of 100 for 14-bit dividends: x / 100 == (x * 5243) >> 19.
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned RecipProdW    = YearW + 13;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef logic [DiffW-1:0] day_num_t;

  // Integer quotient by 100 of a year-sized value.
  function automatic logic [YearW-1:0] div100(input logic [YearW-1:0] x);
    logic [RecipProdW-1:0] p;
    p = RecipProdW'(x) * RecipProdW'(Recip100);
    return YearW'(p[RecipProdW-1:Recip100Shift]);
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] q;
    logic [YearW-1:0] r;
    q = div100(y);
    r = y - YearW'(q * YearW'(100));
    return (y[1:0] == 2'd0 && r != '0) || (r == '0 && q[1:0] == 2'd0);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic [YearW-1:0] y);
    logic [DayW-1:0] len;
    if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      len = 5'd31;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (m == MonthFeb) begin
      len = is_leap(y) ? 5'd29 : 5'd28;
    end else begin
      len = '0;
    end
    return len;
  endfunction

  function automatic logic date_ok(input logic [DayW-1:0] d,
                                   input logic [MonthW-1:0] m,
                                   input logic [YearW-1:0] y);
    logic m_ok;
    logic y_ok;
    m_ok = (m >= MonthJan) && (m <= MonthDec);
    y_ok = (y != '0) && (YearCmpW'(y) <= YearCmpW'(MaxYear));
    return m_ok && y_ok && (d != '0) && (d <= month_len(m, y));
  endfunction

  // Days before the first of each month in a March-based year.
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] mm);
    logic [8:0] off;
    case (mm)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Closed-form Gregorian day number; meaningful for valid dates only.
  function automatic day_num_t day_number(input logic [DayW-1:0] d,
                                          input logic [MonthW-1:0] m,
                                          input logic [YearW-1:0] y);
    logic [YearW-1:0]  yy;
    logic [MonthW-1:0] mm;
    logic [YearW-1:0]  yq4;
    day_num_t          acc;
    yy  = (m < MonthMar) ? (y - YearW'(1)) : y;
    mm  = (m >= MonthMar) ? (m - MonthMar) : (m + 4'd9);
    yq4 = yy >> 2;
    acc = DiffW'(yy) * DiffW'(365);
    acc = acc + DiffW'(yq4) - DiffW'(div100(yy)) + DiffW'(div100(yq4));
    acc = acc + DiffW'(month_offset(mm)) + DiffW'(d);
    return acc;
  endfunction

endpackage

[hw/rtl/days_between_dates_core.sv]
// Gregorian day-difference core: top level, input register and result register.
// Depends on dbd_pkg for widths, the year bound and the calendar functions.
//
// Takes one word of two calendar dates (day, month, year) and returns one word
// holding the signed number of days from the first date to the second, plus a
// validity flag for each date. A date is valid when its month is 1 to 12, its
// day lies within that month (February 29 in Gregorian leap years only) and its
// year is 1 to MaxYear. When either date is invalid the difference reads 0.
// Throughput is one word per cycle while the output is not stalled; an accepted
// word passes through the input register and then the result register.
// Both day numbers are formed in a single combinational pass between those two
// registers (constant multiplies by 365 and a reciprocal of 100), which sets
// the clock limit. in_ready_o follows out_ready_i combinationally through the
// two-stage pipeline: a stage moves when it is empty or the stage after it
// moves, so a waiting result blocks a new word only when stage one is also
// holding a word.
module days_between_dates_core
  import dbd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DayW-1:0]         first_day_i,
  input  logic [MonthW-1:0]       first_month_i,
  input  logic [YearW-1:0]        first_year_i,
  input  logic [DayW-1:0]         second_day_i,
  input  logic [MonthW-1:0]       second_month_i,
  input  logic [YearW-1:0]        second_year_i,

  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DiffW-1:0] day_difference_o,
  output logic                    first_valid_o,
  output logic                    second_valid_o
);

  // Stage one: captured input word.
  logic              s1_valid_q;
  logic [DayW-1:0]   d1_q, d2_q;
  logic [MonthW-1:0] m1_q, m2_q;
  logic [YearW-1:0]  y1_q, y2_q;

  // Stage two: result register.
  logic              s2_valid_q;
  logic [DiffW-1:0]  diff_q, diff_d;
  logic              v1_q, v1_d;
  logic              v2_q, v2_d;

  logic              s2_adv;
  logic              s1_adv;
  day_num_t          dn1, dn2;

  // Advance a stage when it is empty or its contents move on this cycle.
  assign s2_adv     = !s2_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Payload: load only on an accepted word.
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      d1_q <= first_day_i;
      m1_q <= first_month_i;
      y1_q <= first_year_i;
      d2_q <= second_day_i;
      m2_q <= second_month_i;
      y2_q <= second_year_i;
    end
  end

  // Check both dates and take the difference of their day numbers.
  always_comb begin
    v1_d   = date_ok(d1_q, m1_q, y1_q);
    v2_d   = date_ok(d2_q, m2_q, y2_q);
    dn1    = day_number(d1_q, m1_q, y1_q);
    dn2    = day_number(d2_q, m2_q, y2_q);
    // Drop the difference when either date fails the calendar check.
    diff_d = (v1_d && v2_d) ? (dn2 - dn1) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      diff_q <= diff_d;
      v1_q   <= v1_d;
      v2_q   <= v2_d;
    end
  end

  assign out_valid_o      = s2_valid_q;
  assign day_difference_o = $signed(diff_q);
  assign first_valid_o    = v1_q;
  assign second_valid_o   = v2_q;

`ifndef SYNTH
  // An invalid date on either side always yields a zero difference.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(first_valid_o && second_valid_o) |-> day_difference_o == '0)
    else $error("nonzero difference with an invalid date");

  // An empty input stage must always take a word.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  // A word stuck in stage one stays there.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(y1_q) && $stable(y2_q))
    else $error("stalled input word lost or changed");

  // Identical valid dates give a zero difference.
  a_same_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && v1_d && d1_q == d2_q && m1_q == m2_q && y1_q == y2_q
      |-> diff_d == '0)
    else $error("same date gives nonzero difference");

  // A result moves into stage two exactly when stage one held a word.
  a_s2_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv && s1_valid_q |=> out_valid_o)
    else $error("result register failed to load");
`endif

endmodule
